>>> hw/rtl/cht_pkg.sv
// Package for the coordinate hash table probe block.
// Holds table sizes, slot status codes, action codes and the FNV-1a hash constants.
// No dependencies.
`default_nettype none

package cht_pkg;

  localparam int TABLE_SLOTS = 256;
  localparam int COORD_BITS  = 16;

  typedef logic [1:0] status_t;
  typedef logic [1:0] action_t;

  localparam status_t ST_VACANT   = 2'd0;
  localparam status_t ST_OCCUPIED = 2'd1;
  localparam status_t ST_DELETED  = 2'd2;

  localparam action_t ACT_LOOKUP = 2'd0;
  localparam action_t ACT_INSERT = 2'd1;
  localparam action_t ACT_STREAM = 2'd2;
  localparam action_t ACT_NOP    = 2'd3;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

endpackage

`default_nettype wire

>>> hw/rtl/cht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/cht_hash.sv
// FNV-1a hash of a 3-D coordinate key, reduced to a table slot index.
// One multiply per cycle; the table size is a power of two, so the slot is the low bits.
// Depends on cht_pkg.
`default_nettype none

module cht_hash (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    start,
  input  wire logic [cht_pkg::COORD_BITS-1:0]          key_x,
  input  wire logic [cht_pkg::COORD_BITS-1:0]          key_y,
  input  wire logic [cht_pkg::COORD_BITS-1:0]          key_z,
  output logic                                         done,
  output logic [$clog2(cht_pkg::TABLE_SLOTS)-1:0]      slot
);

  localparam int IDX = $clog2(cht_pkg::TABLE_SLOTS);

  typedef enum logic {H_IDLE, H_MIX} hstate_t;

  hstate_t              state_r;
  logic [1:0]           cnt_r;
  logic [31:0]          h_r;
  logic [31:0]          wx_r, wy_r, wz_r;
  logic [IDX-1:0]       slot_r;
  logic                 done_r;
  logic [31:0]          word;
  logic [31:0]          mix;

  always_comb begin
    case (cnt_r)
      2'd0:    word = wx_r;
      2'd1:    word = wy_r;
      default: word = wz_r;
    endcase
    mix = (h_r ^ word) * cht_pkg::FNV_PRIME;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        H_IDLE: begin
          if (start) begin
            h_r     <= cht_pkg::FNV_BASIS;
            wx_r    <= 32'($signed(key_x));
            wy_r    <= 32'($signed(key_y));
            wz_r    <= 32'($signed(key_z));
            cnt_r   <= '0;
            state_r <= H_MIX;
          end
        end
        H_MIX: begin
          h_r   <= mix;
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd2) begin
            cnt_r   <= '0;
            slot_r  <= mix[IDX-1:0];
            done_r  <= 1'b1;
            state_r <= H_IDLE;
          end
        end
        default: state_r <= H_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule

`default_nettype wire

>>> hw/rtl/coord_hash_table_probe.sv
// Top level of the coordinate hash table probe: control sequencer around the slot RAM.
// Depends on cht_pkg, cht_ram and cht_hash.
//
// Usage: an action is accepted when start is high and busy is low. Lookup (0)
// and find-or-insert (1) hash the key, then probe the slot RAM linearly.
// Stream (2) runs find-or-insert for every (x,0,z) key in the square of
// half-width radius around the centre, then sweeps every slot and tombstones
// used entries outside the square. Action 3 changes nothing.
// Each action gives one result, shown for one cycle while out_valid is high;
// the receiver cannot stall, so results are never held back.
// A lookup or insert starts the hash, waits for it, then spends one RAM read
// and one check on each slot probed. Busy drops with the result, so no new
// action is taken before the last one has given its result.
// Stream runs (2*radius+1)^2 such probes and then sweeps all TABLE_SLOTS
// slots. Action 3 answers the cycle after it is accepted and leaves busy low.
// Reset: after rst_n the block clears the slot RAM, one slot per cycle, with
// busy high. The radius register resets to 4 and is written through cfg_valid
// and cfg_data; the user must write it only between actions, as the block
// itself does not enforce this. cfg_ready is always high.
`default_nettype none

module coord_hash_table_probe (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_key_x,
  input  wire logic [15:0] in_key_y,
  input  wire logic [15:0] in_key_z,
  output logic             out_valid,
  output logic             out_found,
  output logic             out_newly_placed,
  output logic             out_table_full,
  output logic [7:0]       out_slot_index,
  output logic [8:0]       out_evicted_count,
  output logic [8:0]       out_live_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data
);

  localparam int TABLE_SLOTS = cht_pkg::TABLE_SLOTS;
  localparam int C   = cht_pkg::COORD_BITS;
  localparam int IDX = $clog2(TABLE_SLOTS);
  localparam int CW  = $clog2(TABLE_SLOTS + 1);
  localparam int EW  = 2 + 3 * C;
  localparam logic [IDX-1:0] LAST = IDX'(TABLE_SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HGO, S_HASH, S_RD, S_CHK, S_SW_RD, S_SW_CHK
  } state_t;

  state_t           state_r;
  cht_pkg::action_t act_r;
  logic [C-1:0]     cx_r, cz_r;
  logic [C-1:0]     kx_r, ky_r, kz_r;
  logic [3:0]       dx_r, dz_r;
  logic [2:0]       rad_r;
  logic [IDX-1:0]   idx_r, p_r, use_r, clr_r;
  logic             have_tomb_r;
  logic [CW-1:0]    live_r, evict_r;
  logic             st_ins_r, st_full_r;

  logic             ov_r, of_r, oi_r, ofull_r;
  logic [7:0]       oslot_r;
  logic [8:0]       oev_r, olive_r;

  logic [C-1:0]     in_x, in_y, in_z;
  logic [3:0]       rad4, nrad4;
  logic [C-1:0]     nrad_c;

  logic             ram_we;
  logic [IDX-1:0]   ram_waddr;
  logic [EW-1:0]    ram_wdata;
  logic [EW-1:0]    ram_rdata;

  cht_pkg::status_t rd_st;
  logic [C-1:0]     rd_x, rd_y, rd_z;
  logic             chk_empty, chk_hit, chk_tomb, last_probe, probe_end, tomb_any;
  logic             is_insert, ins_do, full_now, evict_now;
  logic [IDX-1:0]   use_now;
  logic [C-1:0]     ddx, ddz, adx, adz;

  logic             hash_start, hash_done;
  logic [IDX-1:0]   hash_slot;

  cht_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  cht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key_x (kx_r),
    .key_y (ky_r),
    .key_z (kz_r),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  // Coordinates are kept at C bits; sign-extend to 32 and keep the low bits.
  assign in_x = C'(32'($signed(in_key_x)));
  assign in_y = C'(32'($signed(in_key_y)));
  assign in_z = C'(32'($signed(in_key_z)));

  assign rad4   = {1'b0, rad_r};
  assign nrad4  = 4'd0 - rad4;
  assign nrad_c = C'(0) - C'(rad_r);

  assign hash_start = (state_r == S_HGO);
  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;

  always_comb begin
    rd_st = ram_rdata[EW-1 -: 2];
    rd_z  = ram_rdata[3*C-1 -: C];
    rd_y  = ram_rdata[2*C-1 -: C];
    rd_x  = ram_rdata[C-1:0];

    chk_empty  = (rd_st == cht_pkg::ST_VACANT);
    chk_tomb   = (rd_st == cht_pkg::ST_DELETED);
    chk_hit    = (rd_st == cht_pkg::ST_OCCUPIED) && (rd_x == kx_r) && (rd_y == ky_r) &&
                 (rd_z == kz_r);
    last_probe = (p_r == LAST);
    probe_end  = chk_empty || chk_hit || last_probe;
    tomb_any   = have_tomb_r || chk_tomb;
    use_now    = have_tomb_r ? use_r : idx_r;
    is_insert  = (act_r != cht_pkg::ACT_LOOKUP);

    // The first tombstone passed wins; a probe that ends with neither a hit nor
    // an empty slot still inserts there if one was seen.
    ins_do   = (state_r == S_CHK) && is_insert && !chk_hit &&
               (chk_empty || (last_probe && tomb_any));
    full_now = is_insert && !chk_hit && !chk_empty && last_probe && !tomb_any;

    ddx = rd_x - cx_r;
    ddz = rd_z - cz_r;
    adx = ddx[C-1] ? (C'(0) - ddx) : ddx;
    adz = ddz[C-1] ? (C'(0) - ddz) : ddz;
    evict_now = (state_r == S_SW_CHK) && (rd_st == cht_pkg::ST_OCCUPIED) &&
                ((adx > C'(rad_r)) || (adz > C'(rad_r)));

    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = {cht_pkg::ST_VACANT, {(3*C){1'b0}}};
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
    end else if (ins_do) begin
      ram_we    = 1'b1;
      ram_waddr = use_now;
      ram_wdata = {cht_pkg::ST_OCCUPIED, kz_r, ky_r, kx_r};
    end else if (evict_now) begin
      ram_we    = 1'b1;
      ram_wdata = {cht_pkg::ST_DELETED, {(3*C){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      live_r  <= '0;
      rad_r   <= 3'd4;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cfg_valid) begin
        rad_r <= cfg_data;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + IDX'(1);
          if (clr_r == LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            act_r     <= in_action;
            cx_r      <= in_x;
            cz_r      <= in_z;
            kx_r      <= in_x;
            ky_r      <= in_y;
            kz_r      <= in_z;
            st_ins_r  <= 1'b0;
            st_full_r <= 1'b0;
            case (in_action)
              cht_pkg::ACT_LOOKUP, cht_pkg::ACT_INSERT: begin
                state_r <= S_HGO;
              end
              cht_pkg::ACT_STREAM: begin
                dx_r    <= nrad4;
                dz_r    <= nrad4;
                kx_r    <= in_x + nrad_c;
                ky_r    <= '0;
                kz_r    <= in_z + nrad_c;
                state_r <= S_HGO;
              end
              default: begin
                ov_r    <= 1'b1;
                of_r    <= 1'b0;
                oi_r    <= 1'b0;
                ofull_r <= 1'b0;
                oslot_r <= '0;
                oev_r   <= '0;
                olive_r <= 9'(live_r);
              end
            endcase
          end
        end
        S_HGO: state_r <= S_HASH;
        S_HASH: begin
          if (hash_done) begin
            idx_r       <= hash_slot;
            p_r         <= '0;
            have_tomb_r <= 1'b0;
            state_r     <= S_RD;
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (ins_do) begin
            live_r <= live_r + CW'(1);
          end
          if (probe_end) begin
            if (act_r == cht_pkg::ACT_STREAM) begin
              st_ins_r  <= st_ins_r | ins_do;
              st_full_r <= st_full_r | full_now;
              if (dx_r == rad4) begin
                if (dz_r == rad4) begin
                  idx_r   <= '0;
                  evict_r <= '0;
                  state_r <= S_SW_RD;
                end else begin
                  dx_r    <= nrad4;
                  dz_r    <= dz_r + 4'd1;
                  kx_r    <= cx_r + nrad_c;
                  kz_r    <= cz_r + C'($signed(dz_r)) + C'(1);
                  state_r <= S_HGO;
                end
              end else begin
                dx_r    <= dx_r + 4'd1;
                kx_r    <= cx_r + C'($signed(dx_r)) + C'(1);
                state_r <= S_HGO;
              end
            end else begin
              ov_r    <= 1'b1;
              of_r    <= chk_hit;
              oi_r    <= ins_do;
              ofull_r <= full_now;
              oslot_r <= chk_hit ? 8'(idx_r) : (ins_do ? 8'(use_now) : 8'd0);
              oev_r   <= '0;
              olive_r <= 9'(live_r + CW'(ins_do));
              state_r <= S_IDLE;
            end
          end else begin
            if (chk_tomb && !have_tomb_r) begin
              have_tomb_r <= 1'b1;
              use_r       <= idx_r;
            end
            p_r     <= p_r + IDX'(1);
            idx_r   <= (idx_r == LAST) ? '0 : idx_r + IDX'(1);
            state_r <= S_RD;
          end
        end
        S_SW_RD: state_r <= S_SW_CHK;
        S_SW_CHK: begin
          if (evict_now) begin
            live_r  <= live_r - CW'(1);
            evict_r <= evict_r + CW'(1);
          end
          if (idx_r == LAST) begin
            ov_r    <= 1'b1;
            of_r    <= 1'b0;
            oi_r    <= st_ins_r;
            ofull_r <= st_full_r;
            oslot_r <= '0;
            oev_r   <= 9'(evict_r + CW'(evict_now));
            olive_r <= 9'(live_r - CW'(evict_now));
            state_r <= S_IDLE;
          end else begin
            idx_r   <= idx_r + IDX'(1);
            state_r <= S_SW_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_found         = of_r;
  assign out_newly_placed  = oi_r;
  assign out_table_full    = ofull_r;
  assign out_slot_index    = oslot_r;
  assign out_evicted_count = oev_r;
  assign out_live_count    = olive_r;

`ifndef ASSERT_OFF
  a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> !out_table_full && !out_newly_placed)
    else $error("hit reported together with insert or full");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CW'(TABLE_SLOTS))
    else $error("live entry count exceeds table size");

  a_evict_live: assert property (@(posedge clk) disable iff (!rst_n)
    evict_now |-> live_r != '0)
    else $error("eviction with no live entries");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    ins_do |-> live_r != CW'(TABLE_SLOTS))
    else $error("insertion into a table with every slot used");
`endif

endmodule

`default_nettype wire

>>> dv/coord_hash_table_probe_checker.sv
// Checker for the coordinate hash table probe: watches the action, result and
// radius channels, keeps its own copy of the slot table and compares every result.
// Depends on cht_pkg.
`timescale 1ns / 100ps

module coord_hash_table_probe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_key_x,
  input  logic [15:0] in_key_y,
  input  logic [15:0] in_key_z,
  input  logic        out_valid,
  input  logic        out_found,
  input  logic        out_newly_placed,
  input  logic        out_table_full,
  input  logic [7:0]  out_slot_index,
  input  logic [8:0]  out_evicted_count,
  input  logic [8:0]  out_live_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  output int          errors,
  output int          pending
);

  localparam int SLOTS = 256;

  typedef struct packed {
    logic       found;
    logic       inserted;
    logic       table_full;
    logic [7:0] slot_index;
    logic [8:0] evicted;
    logic [8:0] live;
  } probe_result_t;

  cht_pkg::status_t slot_state [SLOTS];
  logic [47:0]      slot_coord [SLOTS];
  int               live_n;
  logic [2:0]       radius_q;
  probe_result_t    result_q[$];

  function automatic logic [7:0] home_slot(logic [47:0] k);
    logic [31:0] h;
    h = cht_pkg::FNV_BASIS;
    h = (h ^ {{16{k[47]}}, k[47:32]}) * cht_pkg::FNV_PRIME;
    h = (h ^ {{16{k[31]}}, k[31:16]}) * cht_pkg::FNV_PRIME;
    h = (h ^ {{16{k[15]}}, k[15:0]}) * cht_pkg::FNV_PRIME;
    return h[7:0];
  endfunction

  function automatic int find_slot(logic [47:0] k);
    logic [7:0] i;
    i = home_slot(k);
    for (int p = 0; p < SLOTS; p++) begin
      if (slot_state[i] == cht_pkg::ST_VACANT) return -1;
      if (slot_state[i] == cht_pkg::ST_OCCUPIED && slot_coord[i] == k) return int'(i);
      i = i + 8'd1;
    end
    return -1;
  endfunction

  // Reuses the first tombstone passed; -1 when the probe saw no free slot at all.
  function automatic int place_key(logic [47:0] k, output bit hit, output bit ins);
    logic [7:0] i;
    logic [7:0] pick;
    bit have_tomb;
    bit have_free;
    i = home_slot(k);
    pick = 8'd0;
    have_tomb = 0;
    have_free = 0;
    hit = 0;
    ins = 0;
    for (int p = 0; p < SLOTS; p++) begin
      if (slot_state[i] == cht_pkg::ST_VACANT) begin
        if (!have_tomb) pick = i;
        have_free = 1;
        break;
      end
      if (slot_state[i] == cht_pkg::ST_DELETED) begin
        if (!have_tomb) begin
          have_tomb = 1;
          pick = i;
        end
      end else if (slot_coord[i] == k) begin
        hit = 1;
        return int'(i);
      end
      i = i + 8'd1;
    end
    if (!have_free && !have_tomb) return -1;
    slot_state[pick] = cht_pkg::ST_OCCUPIED;
    slot_coord[pick] = k;
    live_n++;
    ins = 1;
    return int'(pick);
  endfunction

  function automatic int coord_gap(logic [15:0] a, logic [15:0] c);
    logic [15:0] d;
    int v;
    d = a - c;
    v = $signed(d);
    return (v < 0) ? -v : v;
  endfunction

  function automatic probe_result_t predict_action(cht_pkg::action_t act, logic [15:0] x,
                                                   logic [15:0] y, logic [15:0] z);
    probe_result_t r;
    int s;
    int rad;
    bit hit;
    bit ins;
    r = '0;
    rad = int'(radius_q);
    if (act == cht_pkg::ACT_LOOKUP) begin
      s = find_slot({x, y, z});
      if (s >= 0) begin
        r.found = 1'b1;
        r.slot_index = s[7:0];
      end
    end else if (act == cht_pkg::ACT_INSERT) begin
      s = place_key({x, y, z}, hit, ins);
      if (s < 0) begin
        r.table_full = 1'b1;
      end else begin
        r.found = hit;
        r.inserted = ins;
        r.slot_index = s[7:0];
      end
    end else if (act == cht_pkg::ACT_STREAM) begin
      for (int dz = -rad; dz <= rad; dz++) begin
        for (int dx = -rad; dx <= rad; dx++) begin
          s = place_key({x + 16'(dx), 16'd0, z + 16'(dz)}, hit, ins);
          if (s < 0) r.table_full = 1'b1;
          else if (ins) r.inserted = 1'b1;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_state[i] != cht_pkg::ST_OCCUPIED) continue;
        if (coord_gap(slot_coord[i][47:32], x) > rad ||
            coord_gap(slot_coord[i][15:0], z) > rad) begin
          slot_state[i] = cht_pkg::ST_DELETED;
          slot_coord[i] = '0;
          live_n--;
          r.evicted = r.evicted + 9'd1;
        end
      end
    end
    r.live = live_n[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    probe_result_t want;
    probe_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] = cht_pkg::ST_VACANT;
        slot_coord[i] = '0;
      end
      live_n = 0;
      radius_q = 3'd4;
      result_q.delete();
    end else begin
      if (out_valid) begin
        got = '{out_found, out_newly_placed, out_table_full, out_slot_index,
                out_evicted_count, out_live_count};
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = result_q.pop_front();
          if (got.found !== want.found || got.inserted !== want.inserted ||
              got.table_full !== want.table_full || got.slot_index !== want.slot_index ||
              got.evicted !== want.evicted || got.live !== want.live) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) radius_q = cfg_data;
      if (start && !busy)
        result_q.push_back(predict_action(in_action, in_key_x, in_key_y, in_key_z));
    end
    pending = result_q.size();
  end

endmodule

>>> dv/coord_hash_table_probe_tb.sv
// Testbench top for the coordinate hash table probe: clock, reset, action and
// radius stimulus, watchdog and verdict. Depends on cht_pkg, the block and the checker.
`timescale 1ns / 100ps

module coord_hash_table_probe_tb;

  localparam int STALL_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [1:0]  in_action = '0;
  logic [15:0] in_key_x = '0;
  logic [15:0] in_key_y = '0;
  logic [15:0] in_key_z = '0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_data = '0;
  logic        busy, out_valid, out_found, out_newly_placed, out_table_full, cfg_ready;
  logic [7:0]  out_slot_index;
  logic [8:0]  out_evicted_count, out_live_count;
  int          errors, pending;
  int          item_count = 0;
  int          burst_left = 0;
  int          stall_cycles = 0;

  coord_hash_table_probe dut (
    .clk, .rst_n, .start, .busy, .in_action, .in_key_x, .in_key_y, .in_key_z,
    .out_valid, .out_found, .out_newly_placed, .out_table_full, .out_slot_index,
    .out_evicted_count, .out_live_count, .cfg_valid, .cfg_ready, .cfg_data
  );

  coord_hash_table_probe_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_action, .in_key_x, .in_key_y, .in_key_z,
    .out_valid, .out_found, .out_newly_placed, .out_table_full, .out_slot_index,
    .out_evicted_count, .out_live_count, .cfg_valid, .cfg_ready, .cfg_data,
    .errors, .pending
  );

  initial forever #10 clk = ~clk;

  // Watchdog on cycles in which no transaction of any channel completes.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_action(cht_pkg::action_t act, logic [15:0] x, logic [15:0] y,
                             logic [15:0] z);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_key_x <= x;
    in_key_y <= y;
    in_key_z <= z;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    item_count++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_radius(logic [2:0] r);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= r;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys near the origin so that hits and stream squares overlap.
  task automatic pick_key(output logic [15:0] x, output logic [15:0] y,
                          output logic [15:0] z);
    if ($urandom_range(0, 9) < 7) begin
      x = 16'($signed($urandom_range(0, 20)) - 10);
      y = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(0, 2));
      z = 16'($signed($urandom_range(0, 20)) - 10);
    end else begin
      x = 16'($urandom());
      y = 16'($urandom());
      z = 16'($urandom());
    end
  endtask

  task automatic random_action();
    logic [15:0] x, y, z;
    int pick;
    pick = $urandom_range(0, 99);
    pick_key(x, y, z);
    if (pick < 48) send_action(cht_pkg::ACT_INSERT, x, y, z);
    else if (pick < 88) send_action(cht_pkg::ACT_LOOKUP, x, y, z);
    else if (pick < 94) send_action(cht_pkg::ACT_NOP, x, y, z);
    else send_action(cht_pkg::ACT_STREAM, x, 16'($urandom()), z);
  endtask

  initial begin
    logic [15:0] x, y, z;
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every action, wrap of the stream square.
    send_action(cht_pkg::ACT_LOOKUP, 16'h8000, 16'h8000, 16'h8000);
    send_action(cht_pkg::ACT_INSERT, 16'h8000, 16'h8000, 16'h8000);
    send_action(cht_pkg::ACT_INSERT, 16'h7fff, 16'h7fff, 16'h7fff);
    send_action(cht_pkg::ACT_INSERT, 16'h8000, 16'h8000, 16'h8000);
    send_action(cht_pkg::ACT_LOOKUP, 16'h7fff, 16'h7fff, 16'h7fff);
    send_action(cht_pkg::ACT_LOOKUP, 16'hffff, 16'hffff, 16'hffff);
    send_action(cht_pkg::ACT_NOP, 16'hffff, 16'hffff, 16'hffff);
    send_action(cht_pkg::ACT_INSERT, 16'd0, 16'd0, 16'd0);
    send_action(cht_pkg::ACT_STREAM, 16'h7fff, 16'hffff, 16'h7fff);
    send_action(cht_pkg::ACT_LOOKUP, 16'h8002, 16'd0, 16'h8001);
    send_action(cht_pkg::ACT_STREAM, 16'h8000, 16'd0, 16'h8000);
    set_radius(3'd0);
    send_action(cht_pkg::ACT_STREAM, 16'd5, 16'd0, 16'hfffb);
    send_action(cht_pkg::ACT_LOOKUP, 16'd5, 16'd0, 16'hfffb);
    send_action(cht_pkg::ACT_INSERT, 16'd5, 16'd0, 16'hfffb);
    send_action(cht_pkg::ACT_INSERT, 16'd6, 16'd0, 16'hfffb);
    set_radius(3'd7);
    send_action(cht_pkg::ACT_STREAM, 16'd0, 16'd0, 16'd0);
    send_action(cht_pkg::ACT_LOOKUP, 16'hfff9, 16'd0, 16'd7);
    send_action(cht_pkg::ACT_INSERT, 16'd20, 16'd1, 16'd20);

    // Random phases, each under its own radius; every value comes up early.
    phase = 0;
    while (item_count < 1550) begin
      set_radius((phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7)));
      repeat ($urandom_range(40, 80)) random_action();
      phase++;
    end

    // Fill the table to capacity, then stream elsewhere against a full table.
    set_radius(3'd7);
    send_action(cht_pkg::ACT_STREAM, 16'd0, 16'd0, 16'd0);
    repeat (60) begin
      x = 16'($urandom());
      y = 16'($urandom());
      z = 16'($urandom());
      send_action(cht_pkg::ACT_INSERT, x, y, z);
    end
    repeat (20) random_action();
    send_action(cht_pkg::ACT_STREAM, 16'd100, 16'd0, 16'd100);
    set_radius(3'd0);
    send_action(cht_pkg::ACT_STREAM, 16'd3000, 16'd0, 16'hf000);
    repeat (40) random_action();

    drain_results();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
